FILE: hw/rtl/gradient_noise_2d_core_macros.svh
// Assertion macros for the gradient noise core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRADIENT_NOISE_2D_CORE_MACROS_SVH
`define GRADIENT_NOISE_2D_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GN_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/gn2d_pkg.sv
// Shared constants, types and helpers for the gradient noise core.
// No dependencies.
`default_nettype none
package gn2d_pkg;
  localparam int FracBits = 16;
  localparam int NoiseW = 19;
  localparam int NStages = 12;
  localparam logic [31:0] C1 = 32'hCC9E2D51;
  localparam logic [31:0] C2 = 32'h1B873593;
  localparam logic [31:0] C3 = 32'hE6546B64;
  localparam logic [31:0] F1 = 32'h85EBCA6B;
  localparam logic [31:0] F2 = 32'hC2B2AE35;
  localparam logic signed [NoiseW-1:0] NoiseMin = -(19'sd262144);
  localparam logic signed [NoiseW-1:0] NoiseMax = 19'sd262143;

  typedef logic [FracBits-1:0] frac_t;
  typedef logic [FracBits:0] wgt_t;
  typedef logic signed [FracBits+2:0] dot_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/gn2d_hash.sv
// Pipelined seeded Murmur3 corner hash, at most two multiplies per stage.
// Depends on gn2d_pkg; every stage advances on en.
`default_nettype none
module gn2d_hash (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] seed,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  output logic [1:0]       gsel
);
  logic [31:0] s1k, s1y, s2h, s2y, s3h, s3k, s4h, s5h, s6h, s7h, s8h;
  logic [31:0] s9h, s10h, s11h;
  always_ff @(posedge clk) begin
    if (en) begin
      s1k <= x * gn2d_pkg::C1;
      s1y <= y;
      s2h <= seed ^ (gn2d_pkg::rotl(s1k, 15) * gn2d_pkg::C2);
      s2y <= s1y;
      s3h <= gn2d_pkg::rotl(s2h, 13) * 32'd5 + gn2d_pkg::C3;
      s3k <= s2y * gn2d_pkg::C1;
      s4h <= s3h ^ (gn2d_pkg::rotl(s3k, 15) * gn2d_pkg::C2);
      s5h <= gn2d_pkg::rotl(s4h, 13) * 32'd5 + gn2d_pkg::C3;
      s6h <= s5h ^ (s5h >> 16);
      s7h <= s6h * gn2d_pkg::F1;
      s8h <= s7h ^ (s7h >> 13);
      s9h <= s8h * gn2d_pkg::F2;
      s10h <= s9h ^ (s9h >> 16);
      s11h <= s10h;
      gsel <= s11h[1:0];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gn2d_fade.sv
// Pipelined quintic fade weight and unsigned fractional offset delay line.
// Depends on gn2d_pkg; every stage advances on en.
`default_nettype none
module gn2d_fade (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire gn2d_pkg::frac_t   t,
  output gn2d_pkg::wgt_t         w,
  output gn2d_pkg::frac_t        t_out
);
  localparam int F = gn2d_pkg::FracBits;
  logic [F+4:0] p;
  logic [2*F+4:0] pt;
  logic [F+4:0] q, q2, q3;
  logic [2*F-1:0] tt;
  logic [F-1:0] s, t1, t2, t3;
  logic [2*F-1:0] st;
  logic [F-1:0] s2;
  logic [2*F+4:0] sq;
  // weight is ready after 7 stages; pad it out to the hash latency
  gn2d_pkg::wgt_t wd [gn2d_pkg::NStages-6];
  gn2d_pkg::frac_t dl [gn2d_pkg::NStages];
  always_ff @(posedge clk) begin
    if (en) begin
      p  <= ((F+5)'(15) << F) - (F+5)'(6 * t);
      t1 <= t;
      pt <= p * t1;
      tt <= t1 * t1;
      t2 <= t1;
      q  <= ((F+5)'(10) << F) - (F+5)'(pt >> F);
      s  <= tt[2*F-1:F];
      t3 <= t2;
      st <= s * t3;
      q2 <= q;
      s2 <= st[2*F-1:F];
      q3 <= q2;
      sq <= s2 * q3;
      wd[0] <= sq[2*F:F];
      for (int i = 1; i < gn2d_pkg::NStages-6; i++) wd[i] <= wd[i-1];
      dl[0] <= t;
      for (int i = 1; i < gn2d_pkg::NStages; i++) dl[i] <= dl[i-1];
    end
  end
  assign w = wd[gn2d_pkg::NStages-7];
  assign t_out = dl[gn2d_pkg::NStages-1];
endmodule
`default_nettype wire

FILE: hw/rtl/gradient_noise_2d_core.sv
// Top level of the 2D gradient noise core: hash, fade and blend pipeline.
// Depends on gn2d_pkg, gn2d_hash, gn2d_fade and the assertion macro header.
//
// channel  dir  handshake            payload
// s_axis   in   tvalid/tready        tdata = pos_x[31:0], pos_y[63:32]
// m_axis   out  tvalid/tready        tdata = noise_value[18:0], zero pad to 24
// cfg      in   cfg_we               cfg_data = seed
// One sample per cycle unless m_axis stalls; data passes the hash and fade stages,
// then the blend stages, then the output register.
// The pipeline moves as a whole while the output register is empty or taken.
// Stalls freeze every stage; rst clears the valid bits and the seed.
`default_nettype none
`include "gradient_noise_2d_core_macros.svh"
module gradient_noise_2d_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // pos_x, pos_y
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // noise_value
);
  localparam int F = gn2d_pkg::FracBits;
  localparam int D = gn2d_pkg::NStages + 5;
  logic [31:0] seed;
  logic [D-1:0] vld;
  logic en;
  logic [31:0] x0, y0, x1, y1;
  logic [1:0] g00, g10, g01, g11;
  gn2d_pkg::wgt_t u, v;
  gn2d_pkg::frac_t fx, fy;
  gn2d_pkg::dot_t d00, d10, d01, d11, a, b, v1;
  gn2d_pkg::wgt_t v0;
  logic signed [20:0] r;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign x0 = {{F{s_axis_tdata[31]}}, s_axis_tdata[31:F]};
  assign y0 = {{F{s_axis_tdata[63]}}, s_axis_tdata[63:32+F]};
  assign x1 = x0 + 32'd1;
  assign y1 = y0 + 32'd1;

  gn2d_hash h00 (.clk, .en, .seed, .x(x0), .y(y0), .gsel(g00));
  gn2d_hash h10 (.clk, .en, .seed, .x(x1), .y(y0), .gsel(g10));
  gn2d_hash h01 (.clk, .en, .seed, .x(x0), .y(y1), .gsel(g01));
  gn2d_hash h11 (.clk, .en, .seed, .x(x1), .y(y1), .gsel(g11));
  gn2d_fade fdx (.clk, .en, .t(s_axis_tdata[F-1:0]), .w(u), .t_out(fx));
  gn2d_fade fdy (.clk, .en, .t(s_axis_tdata[32+F-1:32]), .w(v), .t_out(fy));

  function automatic gn2d_pkg::dot_t dot(input logic [1:0] g,
                                         input gn2d_pkg::dot_t dx,
                                         input gn2d_pkg::dot_t dy);
    dot = (g[0] ? dx : -dx) + (g[1] ? dy : -dy);
  endfunction

  gn2d_pkg::dot_t ex0, ex1, ey0, ey1;
  assign ex0 = gn2d_pkg::dot_t'({1'b0, fx});
  assign ey0 = gn2d_pkg::dot_t'({1'b0, fy});
  assign ex1 = ex0 - (gn2d_pkg::dot_t'(1) <<< F);
  assign ey1 = ey0 - (gn2d_pkg::dot_t'(1) <<< F);

  logic signed [F+20:0] pa, pb, pr;
  gn2d_pkg::wgt_t u1, v2;
  gn2d_pkg::dot_t a1, b1, a2;
  always_ff @(posedge clk) begin
    if (en) begin
      d00 <= dot(g00, ex0, ey0);
      d10 <= dot(g10, ex1, ey0);
      d01 <= dot(g01, ex0, ey1);
      d11 <= dot(g11, ex1, ey1);
      u1 <= u;
      v0 <= v;
      pa <= (d10 - d00) * $signed({1'b0, u1});
      pb <= (d11 - d01) * $signed({1'b0, u1});
      a1 <= d00;
      b1 <= d01;
      v2 <= v0;
      a <= a1 + gn2d_pkg::dot_t'(pa >>> F);
      b <= b1 + gn2d_pkg::dot_t'(pb >>> F);
      v1 <= gn2d_pkg::dot_t'({1'b0, v2});
      pr <= (b - a) * v1;
      a2 <= a;
      r <= 21'(a2) + 21'(pr >>> F);
    end
  end

  logic signed [18:0] sat;
  always_comb begin
    if (r < 21'(gn2d_pkg::NoiseMin)) sat = gn2d_pkg::NoiseMin;
    else if (r > 21'(gn2d_pkg::NoiseMax)) sat = gn2d_pkg::NoiseMax;
    else sat = r[18:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      vld <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) seed <= cfg_data;
      if (en) begin
        vld <= {vld[D-2:0], s_axis_tvalid};
        m_axis_tvalid <= vld[D-1];
        m_axis_tdata <= {5'd0, sat};
      end
    end
  end

  `GN_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `GN_ASSERT_IMPL(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
  `GN_ASSERT_IMPL(a_pad, clk, rst, m_axis_tvalid, m_axis_tdata[23:19] == 5'd0)
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for gradient_noise_2d_core: 2D gradient noise over a Murmur3 corner hash.
// Depends on gn2d_pkg and the core RTL; predicts every sample and compares it in order.
`timescale 1ns / 1ps
module tb;

  localparam int Latency = 20;
  localparam longint CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  gradient_noise_2d_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    bit          known;  // expected value typed in
    logic [18:0] noise;
  } sample_row_t;

  logic [31:0]  seed_q;
  logic [18:0]  noise_q[$];
  int           errors;
  longint       cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("gradient_noise_2d_core regression: fail");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] rol(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] k;
    k = v * 32'hCC9E2D51;
    k = rol(k, 15) * 32'h1B873593;
    h = rol(h ^ k, 13);
    return h * 5 + 32'hE6546B64;
  endfunction

  function automatic logic [31:0] corner_hash(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] h;
    h = mix_round(mix_round(seed_q, x), y);
    h ^= h >> 16;
    h *= 32'h85EBCA6B;
    h ^= h >> 13;
    h *= 32'hC2B2AE35;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic longint fade_weight(input longint t);
    longint p, q, s;
    p = 15 * 65536 - 6 * t;
    q = 10 * 65536 - ((p * t) >>> gn2d_pkg::FracBits);
    s = (t * t) >>> gn2d_pkg::FracBits;
    s = (s * t) >>> gn2d_pkg::FracBits;
    return (s * q) >>> gn2d_pkg::FracBits;
  endfunction

  function automatic longint grad_dot(input logic [31:0] h, input longint dx, input longint dy);
    return (h[0] ? dx : -dx) + (h[1] ? dy : -dy);
  endfunction

  // arithmetic shift of a signed longint floors toward minus infinity
  function automatic longint lerp(input longint a, input longint b, input longint w);
    return a + (((b - a) * w) >>> gn2d_pkg::FracBits);
  endfunction

  function automatic logic [18:0] noise_at(input logic [31:0] px, input logic [31:0] py);
    longint sx, sy, fx, fy, u, v, r, one;
    logic [31:0] x0, y0, x1, y1;
    one = 65536;
    sx = longint'($signed(px));
    sy = longint'($signed(py));
    fx = sx & 16'hFFFF;
    fy = sy & 16'hFFFF;
    x0 = 32'(sx >>> gn2d_pkg::FracBits);
    y0 = 32'(sy >>> gn2d_pkg::FracBits);
    x1 = x0 + 1;  // wraps at the top cell
    y1 = y0 + 1;
    u = fade_weight(fx);
    v = fade_weight(fy);
    r = lerp(lerp(grad_dot(corner_hash(x0, y0), fx, fy),
                  grad_dot(corner_hash(x1, y0), fx - one, fy), u),
             lerp(grad_dot(corner_hash(x0, y1), fx, fy - one),
                  grad_dot(corner_hash(x1, y1), fx - one, fy - one), u), v);
    if (r < -262144) r = -262144;
    if (r > 262143) r = 262143;
    return 19'(r);
  endfunction

  // output side: random backpressure, check against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_q.size() == 0) begin
          report($sformatf("unexpected sample %h", m_axis_tdata));
        end else begin
          if (m_axis_tdata[18:0] !== noise_q[0])
            report($sformatf("noise_value got %h want %h", m_axis_tdata[18:0], noise_q[0]));
          if (m_axis_tdata[23:19] !== 5'd0)
            report($sformatf("pad bits got %h", m_axis_tdata[23:19]));
          void'(noise_q.pop_front());
        end
      end
      if (cycles % 3000 > 2500) m_axis_tready <= 1'b1;
      else if ($urandom_range(99) < 3) m_axis_tready <= 1'b0;
      else if (!m_axis_tready) m_axis_tready <= ($urandom_range(99) < 25);
      else m_axis_tready <= ($urandom_range(99) < 85);
    end
  end

  task automatic send(input logic [31:0] px, input logic [31:0] py,
                      input bit known, input logic [18:0] want, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(2);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {py, px};
    noise_q.push_back(known ? want : noise_at(px, py));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_q = value;
  endtask

  initial begin
    sample_row_t rows[$];
    logic [31:0] seeds[5];
    logic [31:0] x, y;
    int phase_len;
    seeds = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_0001};
    errors = 0;
    cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    seed_q = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lattice points give zero: both fade weights are zero and the base corner
    // sits at zero offset; the other rows are predicted with noise_at
    rows.push_back('{32'h0000_0000, 32'h0000_0000, 1, 19'd0});
    rows.push_back('{32'h0005_0000, 32'hFFFD_0000, 1, 19'd0});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 1, 19'd0});
    rows.push_back('{32'h7FFF_0000, 32'h7FFF_0000, 1, 19'd0});
    rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 19'd0});
    rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 0, 19'd0});
    rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 0, 19'd0});
    rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 19'd0});
    rows.push_back('{32'h0000_8000, 32'h0000_8000, 0, 19'd0});
    rows.push_back('{32'h0000_0001, 32'h0000_FFFF, 0, 19'd0});
    rows.push_back('{32'hFFFF_8000, 32'h0001_4000, 0, 19'd0});
    rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 0, 19'd0});
    rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 0, 19'd0});
    foreach (rows[i]) send(rows[i].px, rows[i].py, rows[i].known, rows[i].noise, 0);
    drain();

    // five seed phases: after each burst, wait for every expected sample
    for (int s = 0; s < 5; s++) begin
      write_seed(s == 4 ? $urandom() : seeds[s]);
      phase_len = 370;
      for (int n = 0; n < phase_len; n++) begin
        case ($urandom_range(3))
          0: begin x = $urandom(); y = $urandom(); end
          1: begin  // small coordinates near the origin
            x = 32'($signed($urandom_range(20 * 65536))) - 32'd655360;
            y = 32'($signed($urandom_range(20 * 65536))) - 32'd655360;
          end
          2: begin  // near the wrap of the cell index
            x = {$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
            y = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
          end
          default: begin  // fraction extremes
            x = {16'($urandom()), $urandom_range(1) ? 16'hFFFF : 16'h0001};
            y = {16'($urandom()), $urandom_range(1) ? 16'h0000 : 16'($urandom())};
          end
        endcase
        send(x, y, 0, 19'd0, (n % 120) < 80);
      end
      drain();
    end

    if (errors == 0) begin
      $display("gradient_noise_2d_core regression: pass");
    end else begin
      $display("gradient_noise_2d_core regression: fail");
    end
    $finish;
  end
endmodule
